FILE: hdl/pta_pkg.sv
// Shared types, constants and helper functions for the pan/tilt aim block.
package pta_pkg;

    // Coordinate and datapath widths
    localparam int COORD_W     = 16;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int SCALE_SHIFT = 56 - COORD_W;
    localparam int DATA_W      = 62;
    localparam int ANG_W       = 32;
    localparam int ROT_W       = 32;
    localparam int PULSE_W     = 12;
    localparam int WIN_W       = 12;
    localparam int GAIN_W      = 31;
    localparam int GPROD_W     = COORD_W + GAIN_W;
    localparam int STAGES_DEF  = 16;
    localparam int STAGES_MAX  = 24;
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;

    // Angles are in 2^-16 servo units; a servo unit is 0.09 degree
    localparam logic signed [ANG_W-1:0] ANG_UNIT = 32'sd65536;
    localparam logic signed [ANG_W-1:0] ANG_90   = 32'sd65536000;
    localparam logic signed [ANG_W-1:0] ANG_180  = 32'sd131072000;
    localparam logic signed [ANG_W-1:0] ANG_500  = 32'sd32768000;

    localparam logic [GAIN_W-1:0]       GAIN_Q30     = 31'd1768195363;
    localparam logic signed [ROT_W-1:0] INV_GAIN_Q30 = 32'sd652032874;

    // Pulse limits and offsets in microseconds
    localparam logic signed [17:0] PULSE_MIN    = 18'sd500;
    localparam logic signed [17:0] PULSE_MAX    = 18'sd2500;
    localparam logic signed [17:0] YAW_OFFSET   = 18'sd415;
    localparam logic signed [17:0] PITCH_OFFSET = 18'sd2125;

    // Register map (word index)
    typedef enum logic [2:0] {
        REG_CAM_X      = 3'd0,
        REG_CAM_Y      = 3'd1,
        REG_CAM_Z      = 3'd2,
        REG_YAW_LOW    = 3'd3,
        REG_YAW_HIGH   = 3'd4,
        REG_PITCH_LOW  = 3'd5,
        REG_PITCH_HIGH = 3'd6
    } reg_idx_t;

    // Request and result payloads
    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } aim_req_t;

    typedef struct packed {
        logic                      aim_ok;
        logic [PULSE_W-1:0]        yaw_pulse;
        logic [PULSE_W-1:0]        pitch_pulse;
        logic signed [15:0]        quat_w;
        logic signed [15:0]        quat_x;
        logic signed [15:0]        quat_y;
        logic signed [15:0]        quat_z;
    } servo_resp_t;

    // CORDIC arctangent table, atan(2^-i) in angle units
    function automatic logic signed [ANG_W-1:0] atan_val(input int i);
        logic signed [ANG_W-1:0] a;
        case (i)
            0:       a = 32'sd32768000;
            1:       a = 32'sd19344080;
            2:       a = 32'sd10220881;
            3:       a = 32'sd5188279;
            4:       a = 32'sd2604207;
            5:       a = 32'sd1303373;
            6:       a = 32'sd651846;
            7:       a = 32'sd325943;
            8:       a = 32'sd162974;
            9:       a = 32'sd81487;
            10:      a = 32'sd40744;
            11:      a = 32'sd20372;
            12:      a = 32'sd10186;
            13:      a = 32'sd5093;
            14:      a = 32'sd2546;
            15:      a = 32'sd1273;
            16:      a = 32'sd637;
            17:      a = 32'sd318;
            18:      a = 32'sd159;
            19:      a = 32'sd80;
            20:      a = 32'sd40;
            21:      a = 32'sd20;
            22:      a = 32'sd10;
            23:      a = 32'sd5;
            default: a = '0;
        endcase
        return a;
    endfunction

    // Q60 product to Q15, round half up, saturate
    function automatic logic signed [15:0] to_q15(input logic signed [63:0] p);
        logic signed [63:0] r;
        r = (p + 64'sd17592186044416) >>> 45;
        if (r > 64'sd32767)
            return 16'sh7fff;
        else if (r < -64'sd32768)
            return 16'sh8000;
        else
            return r[15:0];
    endfunction

endpackage

FILE: hdl/pta_cordic.sv
// Pipelined CORDIC, one micro-rotation per register stage, vectoring or rotation mode.
module pta_cordic
    import pta_pkg::*;
#(
    parameter int STAGES = STAGES_DEF,
    parameter int DW     = DATA_W,
    parameter bit VECTOR = 1'b1,
    parameter int SIDE_W = 1
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [DW-1:0]    in_x,
    input  logic signed [DW-1:0]    in_y,
    input  logic signed [ANG_W-1:0] in_z,
    input  logic [SIDE_W-1:0]       in_side,
    output logic                    out_valid,
    output logic signed [DW-1:0]    out_a,
    output logic signed [DW-1:0]    out_b,
    output logic [SIDE_W-1:0]       out_side
);

    logic signed [DW-1:0]    x_reg    [STAGES];
    logic signed [DW-1:0]    y_reg    [STAGES];
    logic signed [ANG_W-1:0] z_reg    [STAGES];
    logic [SIDE_W-1:0]       side_reg [STAGES];
    logic                    v_reg    [STAGES];

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        logic signed [DW-1:0]    cx;
        logic signed [DW-1:0]    cy;
        logic signed [ANG_W-1:0] cz;
        logic [SIDE_W-1:0]       cs;
        logic                    cv;
        logic                    dir;
        logic signed [DW-1:0]    xs;
        logic signed [DW-1:0]    ys;
        logic signed [ANG_W-1:0] a;

        // stage input: ports for the first stage, else previous stage
        if (i == 0)
        begin : g_first
            assign cx = in_x;
            assign cy = in_y;
            assign cz = in_z;
            assign cs = in_side;
            assign cv = in_valid;
        end
        else
        begin : g_next
            assign cx = x_reg[i-1];
            assign cy = y_reg[i-1];
            assign cz = z_reg[i-1];
            assign cs = side_reg[i-1];
            assign cv = v_reg[i-1];
        end

        // vectoring drives y to zero, rotation drives z to zero
        assign dir = VECTOR ? ~cy[DW-1] : cz[ANG_W-1];
        assign xs  = cy >>> i;
        assign ys  = cx >>> i;
        assign a   = atan_val(i);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i]    <= dir ? cx + xs : cx - xs;
                y_reg[i]    <= dir ? cy - ys : cy + ys;
                z_reg[i]    <= dir ? cz + a  : cz - a;
                side_reg[i] <= cs;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else if (en)
                v_reg[i] <= cv;
        end
    end

    // vectoring: magnitude and angle; rotation: cosine and sine
    assign out_valid = v_reg[STAGES-1];
    assign out_a     = x_reg[STAGES-1];
    assign out_b     = VECTOR ? DW'(z_reg[STAGES-1]) : y_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

FILE: hdl/pan_tilt_aim_to_servo_unit.sv
// Top level: register file, aim pipeline and servo/quaternion output stage.
// Throughput: one request per cycle while the result is not stalled; the three
// CORDIC chains (yaw vectoring, pitch vectoring, paired rotation) are fully
// unrolled into register stages.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// Reset: asynchronous, active low; clears all valid bits and loads register
// defaults (camera 0/-240/-70 mm, windows 160..1960 and 140..1440).
module pan_tilt_aim_to_servo_unit
    import pta_pkg::*;
#(
    parameter int CORDIC_STAGES = STAGES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               point_valid,
    output logic               point_ready,
    input  aim_req_t           point,
    output logic               result_valid,
    input  logic               result_ready,
    output servo_resp_t        result
);

    typedef struct packed {
        logic [GPROD_W-1:0] gp;
        logic               dz_neg;
        logic               dz_pos;
        logic               zero_xy;
        logic               zero_all;
    } yaw_side_t;

    typedef struct packed {
        logic signed [ANG_W-1:0] yaw;
        logic                    dz_pos;
        logic                    zero_xy;
        logic                    zero_all;
    } pitch_side_t;

    typedef struct packed {
        logic               ok;
        logic [PULSE_W-1:0] yaw_pulse;
        logic [PULSE_W-1:0] pitch_pulse;
        logic               neg;
    } rot_side_t;

    function automatic logic [PULSE_W-1:0] sat_pulse(input logic signed [17:0] v);
        if (v < PULSE_MIN)
            return PULSE_W'(PULSE_MIN);
        else if (v > PULSE_MAX)
            return PULSE_W'(PULSE_MAX);
        else
            return v[PULSE_W-1:0];
    endfunction

    // ---------------- configuration registers ----------------
    logic signed [COORD_W-1:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic [WIN_W-1:0]          yaw_low_reg, yaw_high_reg, pitch_low_reg, pitch_high_reg;
    reg_idx_t                  reg_idx;
    logic                      wr_en;

    assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg      <= 16'sd0;
            cam_y_reg      <= -16'sd240;
            cam_z_reg      <= -16'sd70;
            yaw_low_reg    <= 12'd160;
            yaw_high_reg   <= 12'd1960;
            pitch_low_reg  <= 12'd140;
            pitch_high_reg <= 12'd1440;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_CAM_X:      cam_x_reg      <= pwdata[COORD_W-1:0];
                REG_CAM_Y:      cam_y_reg      <= pwdata[COORD_W-1:0];
                REG_CAM_Z:      cam_z_reg      <= pwdata[COORD_W-1:0];
                REG_YAW_LOW:    yaw_low_reg    <= pwdata[WIN_W-1:0];
                REG_YAW_HIGH:   yaw_high_reg   <= pwdata[WIN_W-1:0];
                REG_PITCH_LOW:  pitch_low_reg  <= pwdata[WIN_W-1:0];
                REG_PITCH_HIGH: pitch_high_reg <= pwdata[WIN_W-1:0];
                default:        ;
            endcase
        end
    end

    // read-back
    always_comb
    begin
        unique case (reg_idx)
            REG_CAM_X:      prdata = PDATA_W'(unsigned'(cam_x_reg));
            REG_CAM_Y:      prdata = PDATA_W'(unsigned'(cam_y_reg));
            REG_CAM_Z:      prdata = PDATA_W'(unsigned'(cam_z_reg));
            REG_YAW_LOW:    prdata = PDATA_W'(yaw_low_reg);
            REG_YAW_HIGH:   prdata = PDATA_W'(yaw_high_reg);
            REG_PITCH_LOW:  prdata = PDATA_W'(pitch_low_reg);
            REG_PITCH_HIGH: prdata = PDATA_W'(pitch_high_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic en;
    assign en          = ~result_valid | result_ready;
    assign point_ready = en;

    // ---------------- S1: differences ----------------
    logic                     v1_reg;
    logic signed [DIFF_W-1:0] dx1_reg, dy1_reg, dz1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= point_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx1_reg <= DIFF_W'(point.point_x) - DIFF_W'(cam_x_reg);
            dy1_reg <= DIFF_W'(point.point_y) - DIFF_W'(cam_y_reg);
            dz1_reg <= DIFF_W'(point.point_z) - DIFF_W'(cam_z_reg);
        end
    end

    // ---------------- S2: scale, pre-rotate, dz gain product ----------------
    logic                     v2_reg;
    logic signed [DATA_W-1:0] x2_reg, y2_reg, x2_next, y2_next;
    logic signed [ANG_W-1:0]  base2_reg, base2_next;
    yaw_side_t                ys2_reg, ys2_next;
    logic signed [DATA_W-1:0] sx, sy;
    logic [DIFF_W-1:0]        dz_abs;

    always_comb
    begin
        sx = DATA_W'(dx1_reg) <<< SCALE_SHIFT;
        sy = DATA_W'(dy1_reg) <<< SCALE_SHIFT;
        // target behind the yaw axis: turn by half a circle first
        if (dx1_reg > 0)
        begin
            x2_next    = sx;
            y2_next    = -sy;
            base2_next = sy[DATA_W-1] ? -ANG_180 : ANG_180;
        end
        else
        begin
            x2_next    = -sx;
            y2_next    = sy;
            base2_next = '0;
        end
        dz_abs            = dz1_reg[DIFF_W-1] ? unsigned'(-dz1_reg) : unsigned'(dz1_reg);
        ys2_next.gp       = GPROD_W'(dz_abs[COORD_W-1:0]) * GPROD_W'(GAIN_Q30);
        ys2_next.dz_neg   = dz1_reg[DIFF_W-1];
        ys2_next.dz_pos   = (dz1_reg > 0);
        ys2_next.zero_xy  = (dx1_reg == '0) && (dy1_reg == '0);
        ys2_next.zero_all = (dx1_reg == '0) && (dy1_reg == '0) && (dz1_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x2_reg    <= x2_next;
            y2_reg    <= y2_next;
            base2_reg <= base2_next;
            ys2_reg   <= ys2_next;
        end
    end

    // ---------------- yaw vectoring CORDIC ----------------
    logic                     yv_valid;
    logic signed [DATA_W-1:0] yv_mag, yv_ang;
    logic [$bits(yaw_side_t)-1:0] yv_side_bits;
    yaw_side_t                yv_side;

    pta_cordic #(
        .STAGES (CORDIC_STAGES),
        .DW     (DATA_W),
        .VECTOR (1'b1),
        .SIDE_W ($bits(yaw_side_t))
    ) u_yaw_vec (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2_reg),
        .in_x      (x2_reg),
        .in_y      (y2_reg),
        .in_z      (base2_reg),
        .in_side   (ys2_reg),
        .out_valid (yv_valid),
        .out_a     (yv_mag),
        .out_b     (yv_ang),
        .out_side  (yv_side_bits)
    );

    assign yv_side = yaw_side_t'(yv_side_bits);

    // ---------------- S3: signed scaled dz ----------------
    logic                     v3_reg;
    logic signed [DATA_W-1:0] mag3_reg, gz3_reg, gz3_next;
    pitch_side_t              ps3_reg, ps3_next;

    always_comb
    begin
        gz3_next = signed'(DATA_W'(yv_side.gp)) <<< (SCALE_SHIFT - 30);
        if (yv_side.dz_neg)
            gz3_next = -gz3_next;
        ps3_next.yaw      = yv_ang[ANG_W-1:0];
        ps3_next.dz_pos   = yv_side.dz_pos;
        ps3_next.zero_xy  = yv_side.zero_xy;
        ps3_next.zero_all = yv_side.zero_all;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= yv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag3_reg <= yv_mag;
            gz3_reg  <= gz3_next;
            ps3_reg  <= ps3_next;
        end
    end

    // ---------------- pitch vectoring CORDIC ----------------
    logic                     pv_valid;
    logic signed [DATA_W-1:0] pv_ang;
    logic [$bits(pitch_side_t)-1:0] pv_side_bits;
    pitch_side_t              pv_side;

    pta_cordic #(
        .STAGES (CORDIC_STAGES),
        .DW     (DATA_W),
        .VECTOR (1'b1),
        .SIDE_W ($bits(pitch_side_t))
    ) u_pitch_vec (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .in_x      (mag3_reg),
        .in_y      (gz3_reg),
        .in_z      ('0),
        .in_side   (ps3_reg),
        .out_valid (pv_valid),
        .out_a     (),
        .out_b     (pv_ang),
        .out_side  (pv_side_bits)
    );

    assign pv_side = pitch_side_t'(pv_side_bits);

    // ---------------- S4: special cases, window check, fallback ----------------
    logic                    v4_reg, ok4_reg, ok4_next;
    logic signed [ANG_W-1:0] yaw4_reg, yaw4_next, pitch4_reg, pitch4_next;

    always_comb
    begin
        ok4_next    = 1'b1;
        yaw4_next   = pv_side.yaw;
        pitch4_next = -pv_ang[ANG_W-1:0];
        priority if (pv_side.zero_all)
            ok4_next = 1'b0;
        else if (pv_side.zero_xy)
        begin
            // straight up or down: yaw fixed at half a circle
            yaw4_next   = ANG_180;
            pitch4_next = pv_side.dz_pos ? -ANG_90 : ANG_90;
        end
        else
            ok4_next = 1'b1;
        if (yaw4_next   > signed'({4'b0, yaw_high_reg,   16'b0}) ||
            yaw4_next   < signed'({4'b0, yaw_low_reg,    16'b0}) ||
            pitch4_next > signed'({4'b0, pitch_high_reg, 16'b0}) ||
            pitch4_next < signed'({4'b0, pitch_low_reg,  16'b0}))
            ok4_next = 1'b0;
        if (!ok4_next)
        begin
            yaw4_next   = ANG_90;
            pitch4_next = ANG_500;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= pv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok4_reg    <= ok4_next;
            yaw4_reg   <= yaw4_next;
            pitch4_reg <= pitch4_next;
        end
    end

    // ---------------- S5: half angles, fold, pulses ----------------
    logic                    v5_reg;
    logic signed [ANG_W-1:0] hy5_reg, hy5_next, hp5_reg, half;
    rot_side_t               rs5_reg, rs5_next;
    logic signed [ANG_W-1:0] neg_pitch;

    always_comb
    begin
        half          = (yaw4_reg - ANG_90) >>> 1;
        rs5_next.neg  = 1'b0;
        hy5_next      = half;
        // half yaw beyond a quarter turn: fold and negate sin/cos later
        if (half > ANG_90)
        begin
            hy5_next     = half - ANG_180;
            rs5_next.neg = 1'b1;
        end
        else if (half < -ANG_90)
        begin
            hy5_next     = half + ANG_180;
            rs5_next.neg = 1'b1;
        end
        neg_pitch            = -pitch4_reg;
        rs5_next.ok          = ok4_reg;
        rs5_next.yaw_pulse   = sat_pulse(18'(yaw4_reg >>> 16) + YAW_OFFSET);
        rs5_next.pitch_pulse = sat_pulse(18'(neg_pitch >>> 16) + PITCH_OFFSET);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (en)
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hy5_reg <= hy5_next;
            hp5_reg <= pitch4_reg >>> 1;
            rs5_reg <= rs5_next;
        end
    end

    // ---------------- rotation CORDICs: yaw and pitch sin/cos ----------------
    logic                    ry_valid;
    logic signed [ROT_W-1:0] ry_cos, ry_sin, rp_cos, rp_sin;
    logic [$bits(rot_side_t)-1:0] ry_side_bits;
    rot_side_t               ry_side;

    pta_cordic #(
        .STAGES (CORDIC_STAGES),
        .DW     (ROT_W),
        .VECTOR (1'b0),
        .SIDE_W ($bits(rot_side_t))
    ) u_yaw_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v5_reg),
        .in_x      (INV_GAIN_Q30),
        .in_y      ('0),
        .in_z      (hy5_reg),
        .in_side   (rs5_reg),
        .out_valid (ry_valid),
        .out_a     (ry_cos),
        .out_b     (ry_sin),
        .out_side  (ry_side_bits)
    );

    pta_cordic #(
        .STAGES (CORDIC_STAGES),
        .DW     (ROT_W),
        .VECTOR (1'b0),
        .SIDE_W (1)
    ) u_pitch_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v5_reg),
        .in_x      (INV_GAIN_Q30),
        .in_y      ('0),
        .in_z      (hp5_reg),
        .in_side   (1'b0),
        .out_valid (),
        .out_a     (rp_cos),
        .out_b     (rp_sin),
        .out_side  ()
    );

    assign ry_side = rot_side_t'(ry_side_bits);

    // ---------------- S6: sign fix-up ----------------
    logic                    v6_reg;
    logic signed [ROT_W-1:0] cy6_reg, sy6_reg, cp6_reg, nsp6_reg;
    rot_side_t               rs6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else if (en)
            v6_reg <= ry_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cy6_reg  <= ry_side.neg ? -ry_cos : ry_cos;
            sy6_reg  <= ry_side.neg ? -ry_sin : ry_sin;
            cp6_reg  <= rp_cos;
            nsp6_reg <= -rp_sin;
            rs6_reg  <= ry_side;
        end
    end

    // ---------------- S7: quaternion products ----------------
    logic               v7_reg;
    logic signed [63:0] pw7_reg, px7_reg, py7_reg, pz7_reg;
    rot_side_t          rs7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v7_reg <= 1'b0;
        else if (en)
            v7_reg <= v6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pw7_reg <= 64'(cy6_reg) * 64'(cp6_reg);
            px7_reg <= 64'(cy6_reg) * 64'(nsp6_reg);
            py7_reg <= 64'(sy6_reg) * 64'(nsp6_reg);
            pz7_reg <= 64'(sy6_reg) * 64'(cp6_reg);
            rs7_reg <= rs6_reg;
        end
    end

    // ---------------- S8: output register ----------------
    logic        v8_reg;
    servo_resp_t res8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v8_reg <= 1'b0;
        else if (en)
            v8_reg <= v7_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res8_reg.aim_ok      <= rs7_reg.ok;
            res8_reg.yaw_pulse   <= rs7_reg.yaw_pulse;
            res8_reg.pitch_pulse <= rs7_reg.pitch_pulse;
            res8_reg.quat_w      <= to_q15(pw7_reg);
            res8_reg.quat_x      <= to_q15(px7_reg);
            res8_reg.quat_y      <= to_q15(py7_reg);
            res8_reg.quat_z      <= to_q15(pz7_reg);
        end
    end

    assign result_valid = v8_reg;
    assign result       = res8_reg;

endmodule

FILE: hdl/pta_checker.sv
// Port-level checker for the aim-to-servo block, bound to the top level.
module pta_checker
    import pta_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               point_ready,
    input logic               result_valid,
    input logic               result_ready,
    input servo_resp_t        result
);

    // a held result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // requests are refused only behind a stalled result
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !point_ready |-> result_valid && !result_ready)
        else $error("request refused without a stall");

    // pulses stay inside the servo range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.yaw_pulse >= 12'd500 && result.yaw_pulse <= 12'd2500 &&
                         result.pitch_pulse >= 12'd500 && result.pitch_pulse <= 12'd2500)
        else $error("pulse outside servo range");

    // fallback pose gives the parked pulses
    a_fallback: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.aim_ok |->
            result.yaw_pulse == 12'd1415 && result.pitch_pulse == 12'd1625)
        else $error("fallback pulses wrong");

endmodule

bind pan_tilt_aim_to_servo_unit pta_checker u_pta_checker (.*);

FILE: test/aim_checker.sv
// Checker for the pan/tilt aim block: predicts servo pulses and quaternion per request.
`timescale 1ns / 1ps

module aim_checker
    import pta_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic        point_valid,
    input  logic        point_ready,
    input  aim_req_t    point,
    input  logic        result_valid,
    input  logic        result_ready,
    input  servo_resp_t result,
    output int          fail_count,
    output int          pending_count,
    output int          result_count
);

    // Shadow copy of the register file
    logic [15:0] cam_x_q, cam_y_q, cam_z_q;
    logic [11:0] yaw_lo_q, yaw_hi_q, pitch_lo_q, pitch_hi_q;

    servo_resp_t aim_queue[$];

    localparam longint UNIT = 65536;
    localparam longint A90  = 1000 * 65536;
    localparam longint A180 = 2000 * 65536;

    function automatic longint arctan_step(input int i);
        longint t[24] = '{32768000, 19344080, 10220881, 5188279, 2604207, 1303373,
                          651846, 325943, 162974, 81487, 40744, 20372, 10186, 5093,
                          2546, 1273, 637, 318, 159, 80, 40, 20, 10, 5};
        return t[i];
    endfunction

    // Vectoring pass: returns the angle, gain-scaled magnitude through mag
    function automatic longint vector_angle(input longint x0, input longint y0,
                                            output longint mag);
        longint x, y, z, xs, ys;
        x = x0;
        y = y0;
        z = 0;
        for (int i = 0; i < STAGES_DEF; i++)
        begin
            xs = y >>> i;
            ys = x >>> i;
            if (y >= 0)
            begin
                x += xs; y -= ys; z += arctan_step(i);
            end
            else
            begin
                x -= xs; y += ys; z -= arctan_step(i);
            end
        end
        mag = x;
        return z;
    endfunction

    // Rotation pass: Q30 cosine and sine of an angle within a quarter turn
    task automatic rotate_unit(input longint z0, output longint c, output longint s);
        longint x, y, z, xs, ys;
        x = 652032874;
        y = 0;
        z = z0;
        for (int i = 0; i < STAGES_DEF; i++)
        begin
            xs = y >>> i;
            ys = x >>> i;
            if (z >= 0)
            begin
                x -= xs; y += ys; z -= arctan_step(i);
            end
            else
            begin
                x += xs; y -= ys; z += arctan_step(i);
            end
        end
        c = x;
        s = y;
    endtask

    function automatic longint scale_by_gain(input longint v);
        longint m, r;
        m = v < 0 ? -v : v;
        r = (m >>> 30) * 1768195363 + (((m & 64'd1073741823) * 1768195363) >>> 30);
        return v < 0 ? -r : r;
    endfunction

    function automatic logic signed [15:0] round_q15(input longint v);
        longint r;
        r = (v + (64'sd1 <<< 44)) >>> 45;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    function automatic logic [11:0] clamp_pulse(input longint v);
        longint r;
        r = v >>> 16;
        if (r < 500)
            r = 500;
        if (r > 2500)
            r = 2500;
        return r[11:0];
    endfunction

    task automatic predict_aim(input aim_req_t p, output servo_resp_t o);
        longint dx, dy, dz, yaw, pitch, mag, half, cy, sy, cp, sp, bx, by, base;
        bit ok;
        dx = longint'(p.point_x) - longint'($signed(cam_x_q));
        dy = longint'(p.point_y) - longint'($signed(cam_y_q));
        dz = longint'(p.point_z) - longint'($signed(cam_z_q));
        ok = 1;
        if (dx == 0 && dy == 0 && dz == 0)
        begin
            ok = 0; yaw = 0; pitch = 0;
        end
        else if (dx == 0 && dy == 0)
        begin
            yaw = A180;
            pitch = dz > 0 ? -A90 : A90;
        end
        else
        begin
            bx = -dx <<< SCALE_SHIFT;
            by = dy <<< SCALE_SHIFT;
            base = 0;
            if (bx < 0)
            begin
                base = by >= 0 ? A180 : -A180;
                bx = -bx;
                by = -by;
            end
            yaw = base + vector_angle(bx, by, mag);
            pitch = -vector_angle(mag, scale_by_gain(dz <<< SCALE_SHIFT), mag);
        end
        if (ok && (yaw > longint'(yaw_hi_q) * UNIT || yaw < longint'(yaw_lo_q) * UNIT ||
                   pitch > longint'(pitch_hi_q) * UNIT || pitch < longint'(pitch_lo_q) * UNIT))
            ok = 0;
        if (!ok)
        begin
            yaw = A90;
            pitch = 500 * UNIT;
        end
        // half yaw beyond a quarter turn is folded with sign flip
        half = (yaw - A90) >>> 1;
        if (half > A90)
        begin
            rotate_unit(half - A180, cy, sy); cy = -cy; sy = -sy;
        end
        else if (half < -A90)
        begin
            rotate_unit(half + A180, cy, sy); cy = -cy; sy = -sy;
        end
        else
            rotate_unit(half, cy, sy);
        rotate_unit(pitch >>> 1, cp, sp);
        o.aim_ok      = ok;
        o.yaw_pulse   = clamp_pulse(yaw + 415 * UNIT);
        o.pitch_pulse = clamp_pulse(2125 * UNIT - pitch);
        o.quat_w      = round_q15(cy * cp);
        o.quat_x      = round_q15(-(cy * sp));
        o.quat_y      = round_q15(-(sy * sp));
        o.quat_z      = round_q15(sy * cp);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        servo_resp_t exp_r;
        if (!rst_n)
        begin
            cam_x_q = 16'd0; cam_y_q = -16'sd240; cam_z_q = -16'sd70;
            yaw_lo_q = 12'd160; yaw_hi_q = 12'd1960;
            pitch_lo_q = 12'd140; pitch_hi_q = 12'd1440;
            fail_count <= 0;
            result_count <= 0;
            aim_queue.delete();
            pending_count <= 0;
        end
        else
        begin
            // result side first: it belongs to earlier requests
            if (result_valid && result_ready)
            begin
                result_count <= result_count + 1;
                if (aim_queue.size() == 0)
                begin
                    $error("unexpected result %p", result);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = aim_queue.pop_front();
                    if (exp_r != result)
                    begin
                        fail_count <= fail_count + 1;
                        if (exp_r.aim_ok != result.aim_ok)
                            $error("aim_ok exp %0d got %0d", exp_r.aim_ok, result.aim_ok);
                        if (exp_r.yaw_pulse != result.yaw_pulse)
                            $error("yaw_pulse exp %0d got %0d", exp_r.yaw_pulse, result.yaw_pulse);
                        if (exp_r.pitch_pulse != result.pitch_pulse)
                            $error("pitch_pulse exp %0d got %0d",
                                   exp_r.pitch_pulse, result.pitch_pulse);
                        if (exp_r.quat_w != result.quat_w)
                            $error("quat_w exp %0d got %0d", exp_r.quat_w, result.quat_w);
                        if (exp_r.quat_x != result.quat_x)
                            $error("quat_x exp %0d got %0d", exp_r.quat_x, result.quat_x);
                        if (exp_r.quat_y != result.quat_y)
                            $error("quat_y exp %0d got %0d", exp_r.quat_y, result.quat_y);
                        if (exp_r.quat_z != result.quat_z)
                            $error("quat_z exp %0d got %0d", exp_r.quat_z, result.quat_z);
                    end
                end
            end
            if (point_valid && point_ready)
            begin
                predict_aim(point, exp_r);
                aim_queue.push_back(exp_r);
            end
            pending_count <= aim_queue.size();
            // register writes
            if (psel && penable && pwrite)
            begin
                case (paddr[4:2])
                    REG_CAM_X:      cam_x_q = pwdata[15:0];
                    REG_CAM_Y:      cam_y_q = pwdata[15:0];
                    REG_CAM_Z:      cam_z_q = pwdata[15:0];
                    REG_YAW_LOW:    yaw_lo_q = pwdata[11:0];
                    REG_YAW_HIGH:   yaw_hi_q = pwdata[11:0];
                    REG_PITCH_LOW:  pitch_lo_q = pwdata[11:0];
                    REG_PITCH_HIGH: pitch_hi_q = pwdata[11:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

FILE: test/tb_top.sv
// Top of the aim block testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import pta_pkg::*;

    localparam int LATENCY   = 3 * STAGES_DEF + 8;
    localparam int MAX_CYCLES = 400000;

    logic clk, rst_n;
    logic psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata, prdata;
    logic pready;
    logic point_valid, point_ready, result_valid, result_ready;
    aim_req_t point;
    servo_resp_t result;
    int fail_count, pending_count, result_count;
    int cycle_count;
    bit hold_off, calm;

    pan_tilt_aim_to_servo_unit u_top (.*);

    aim_checker u_checker (.*);

    always
    begin
        clk = 1'b1; #5;
        clk = 1'b0; #5;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("pan_tilt_aim_to_servo_unit test failed");
            $finish;
        end
    end

    // Receiver: random stalls, a long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (hold_off)
            result_ready <= 1'b0;
        else
            result_ready <= calm ? 1'b1 : ($urandom_range(99) >= 28);
    end

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= PADDR_W'(idx) << 2; pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic drain();
        while (pending_count != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // Offer one request; called at a falling edge
    task automatic send_point(input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] z);
        if (!calm)
            while ($urandom_range(99) < 28)
            begin
                point_valid <= 1'b0;
                @(negedge clk);
            end
        point_valid <= 1'b1;
        point <= '{point_x: x, point_y: y, point_z: z};
        @(posedge clk);
        while (!point_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic finish_burst();
        point_valid <= 1'b0;
    endtask

    task automatic random_points(input int n, input int mode);
        logic [15:0] x, y, z;
        for (int i = 0; i < n; i++)
        begin
            if (mode == 0 || $urandom_range(3) == 0)
            begin
                x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
            end
            else
            begin
                // near the camera so windows are hit either way
                x = 16'($signed($urandom_range(4000)) - 2000);
                y = 16'($signed($urandom_range(4000)) - 2240);
                z = 16'($signed($urandom_range(2000)) - 1070);
            end
            send_point(x, y, z);
        end
        finish_burst();
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        point_valid = 0; point = '0; hold_off = 0; calm = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: zero difference, straight up/down, field extremes
        send_point(16'd0, -16'sd240, -16'sd70);
        send_point(16'd0, -16'sd240, 16'd1000);
        send_point(16'd0, -16'sd240, -16'sd2000);
        send_point(16'h7fff, 16'h7fff, 16'h7fff);
        send_point(16'h8000, 16'h8000, 16'h8000);
        send_point(16'h7fff, 16'h8000, 16'd0);
        send_point(16'h8000, 16'h7fff, 16'hffff);
        send_point(-16'sd1000, -16'sd240, -16'sd70);
        send_point(16'd1000, -16'sd240, -16'sd70);
        send_point(16'd0, 16'd760, -16'sd70);
        send_point(16'd0, -16'sd1240, -16'sd70);
        send_point(16'd1000, 16'd760, 16'd500);
        send_point(-16'sd1000, -16'sd1240, -16'sd500);
        finish_burst();
        drain();

        // Extreme camera and wide windows
        write_reg(REG_CAM_X, 32'h0000_7fff);
        write_reg(REG_CAM_Y, 32'h0000_8000);
        write_reg(REG_CAM_Z, 32'h0000_7fff);
        write_reg(REG_YAW_LOW, 32'd0);
        write_reg(REG_YAW_HIGH, 32'd4095);
        write_reg(REG_PITCH_LOW, 32'd0);
        write_reg(REG_PITCH_HIGH, 32'd4095);
        send_point(16'h7fff, 16'h8000, 16'h7fff);
        send_point(16'h8000, 16'h7fff, 16'h8000);
        random_points(150, 0);
        drain();

        // Inverted windows: nothing can be pointed at
        write_reg(REG_CAM_X, 32'hffff_8000);
        write_reg(REG_YAW_LOW, 32'd2500);
        write_reg(REG_YAW_HIGH, 32'd0);
        write_reg(REG_PITCH_LOW, 32'd4095);
        write_reg(REG_PITCH_HIGH, 32'd0);
        random_points(100, 0);
        drain();

        // Defaults again, long receiver hold-off while requests pile up
        write_reg(REG_CAM_X, 32'd0);
        write_reg(REG_CAM_Y, 32'hffff_ff10);
        write_reg(REG_CAM_Z, 32'hffff_ffba);
        write_reg(REG_YAW_LOW, 32'd160);
        write_reg(REG_YAW_HIGH, 32'd1960);
        write_reg(REG_PITCH_LOW, 32'd140);
        write_reg(REG_PITCH_HIGH, 32'd1440);
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge clk);
                hold_off = 0;
            end
            random_points(150, 1);
        join
        drain();

        // Stretch with no idling on either side
        calm = 1;
        random_points(200, 1);
        calm = 0;
        drain();

        // Narrow windows, random camera
        write_reg(REG_CAM_X, $urandom_range(400));
        write_reg(REG_CAM_Y, $urandom_range(400));
        write_reg(REG_CAM_Z, $urandom_range(400));
        write_reg(REG_YAW_LOW, 32'd800);
        write_reg(REG_YAW_HIGH, 32'd1200);
        write_reg(REG_PITCH_LOW, 32'd300);
        write_reg(REG_PITCH_HIGH, 32'd700);
        random_points(400, 1);
        drain();

        $display("Covered %0d results over five register settings, incl. extremes,", result_count);
        $display("inverted windows, a long output stall and a gap-free stretch.");
        if (fail_count == 0)
            $display("pan_tilt_aim_to_servo_unit test passed");
        else
            $display("pan_tilt_aim_to_servo_unit test failed");
        $finish;
    end

endmodule
